// ===== src/rau_pkg.sv =====
// Package for the rational arithmetic unit: operation codes, status codes.
// No dependencies.
package rau_pkg;

  typedef enum logic [3:0] {
    FN_NORM = 4'd0, FN_ADD = 4'd1, FN_SUB = 4'd2, FN_MUL = 4'd3, FN_DIV = 4'd4,
    FN_EQ = 4'd5, FN_NE = 4'd6, FN_LT = 4'd7, FN_LE = 4'd8, FN_GE = 4'd9,
    FN_GT = 4'd10
  } func_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

endpackage

// ===== src/rational_arith_unit_top.sv =====
// Top level of the rational arithmetic unit: stream ports, sequencer, one
// shared multiplier, and the gcd unit. Depends on rau_pkg and rau_gcd.
// One item at a time: cross products go through one 32x32 multiplier in
// turn, then the binary gcd of the 64-bit result reduces the fraction and
// two bit-serial quotients divide the gcd out; comparisons and errors skip
// the gcd. The result is held in an output register until taken; s_tready
// is low while an item is in work.
module rational_arith_unit_top #(
  parameter int WORD_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,  // a_num, a_den, b_num, b_den (32 each)
  input  logic [3:0]   s_tuser,  // func
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,  // res_num[31:0], res_den[62:32], cmp_true[63]
  output logic [1:0]   m_tuser   // status
);
  localparam int W = WORD_WIDTH;
  localparam int PW = 2 * W;
  typedef enum logic [2:0] {S_IDLE, S_MUL, S_COMB, S_GCD, S_FIN, S_OUT} st_t;
  st_t st;
  logic [3:0] fn;
  logic [W-1:0] mag [4];
  logic [3:0] neg;
  logic [1:0] mcnt;
  logic [PW-1:0] prod [4];
  logic [PW-1:0] nmag, dmag;
  logic nneg, dneg;
  logic gstart, gdone, gstart_next, in_zden;
  logic [PW-1:0] gn, gd;
  logic [PW-1:0] mres;
  logic [W-1:0] ma, mb;

  function automatic logic [W-1:0] absw(input logic [31:0] x);
    absw = x[W-1] ? (~x[W-1:0] + 1'b1) : x[W-1:0];
  endfunction

  // Multiply schedule: 0 an*bd, 1 bn*ad, 2 ad*bd, 3 an*bn
  always_comb begin
    unique case (mcnt)
      2'd0: begin ma = mag[0]; mb = mag[3]; end
      2'd1: begin ma = mag[2]; mb = mag[1]; end
      2'd2: begin ma = mag[1]; mb = mag[3]; end
      default: begin ma = mag[0]; mb = mag[2]; end
    endcase
  end
  assign mres = PW'(ma) * PW'(mb);

  rau_gcd #(.W(PW)) u_gcd (.clk, .rst, .start(gstart), .n_in(nmag), .d_in(dmag),
    .done(gdone), .n_out(gn), .d_out(gd));

  logic [PW-1:0] x_m, y_m, dif_m;
  logic x_n, y_n, dif_n, ge_xy;
  logic rneg, eqf, ltf, cmpr;
  logic [PW-1:0] lim;

  always_comb begin
    x_m = prod[0]; x_n = (neg[0] ^ neg[3]) && prod[0] != '0;
    y_m = prod[1]; y_n = (neg[2] ^ neg[1]) && prod[1] != '0;
    if (fn != 4'(rau_pkg::FN_ADD)) y_n = !y_n && y_m != '0;
    ge_xy = x_m >= y_m;
    if (x_n == y_n) begin dif_m = x_m + y_m; dif_n = x_n; end
    else if (ge_xy) begin dif_m = x_m - y_m; dif_n = x_n; end
    else begin dif_m = y_m - x_m; dif_n = y_n; end
    if (dif_m == '0) dif_n = 1'b0;
    eqf = dif_m == '0;
    ltf = !eqf && (dif_n != (neg[1] ^ neg[3]));
    unique case (fn)
      4'(rau_pkg::FN_EQ): cmpr = eqf;
      4'(rau_pkg::FN_NE): cmpr = !eqf;
      4'(rau_pkg::FN_LT): cmpr = ltf;
      4'(rau_pkg::FN_LE): cmpr = ltf || eqf;
      4'(rau_pkg::FN_GE): cmpr = !ltf;
      default:            cmpr = !ltf && !eqf;
    endcase
    rneg = (nneg != dneg) && gn != '0;
    lim = PW'(1) << (W - 1);
    in_zden = s_tdata[W-1+32:32] == '0 ||
              (s_tuser != 4'(rau_pkg::FN_NORM) && s_tdata[96+W-1:96] == '0);
    // gcd starts right after a normalize is accepted or after the cross products
    gstart_next = (st == S_IDLE && s_tvalid && s_tready &&
                   s_tuser == 4'(rau_pkg::FN_NORM) && !in_zden) ||
                  (st == S_COMB && fn < 4'(rau_pkg::FN_EQ) &&
                   !(fn == 4'(rau_pkg::FN_DIV) && prod[1] == '0));
  end

  assign s_tready = (st == S_IDLE) && !m_tvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      m_tvalid <= 1'b0;
      gstart <= 1'b0;
    end else begin
      gstart <= gstart_next;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (st)
        S_IDLE: if (s_tvalid && s_tready) begin
          fn <= s_tuser;
          mag[0] <= absw(s_tdata[31:0]);   neg[0] <= s_tdata[W-1];
          mag[1] <= absw(s_tdata[63:32]);  neg[1] <= s_tdata[32+W-1];
          mag[2] <= absw(s_tdata[95:64]);  neg[2] <= s_tdata[64+W-1];
          mag[3] <= absw(s_tdata[127:96]); neg[3] <= s_tdata[96+W-1];
          mcnt <= '0;
          m_tdata <= '0;
          if (s_tuser > 4'(rau_pkg::FN_GT)) begin
            m_tuser <= rau_pkg::ST_OK; st <= S_OUT;
          end else if (in_zden) begin
            m_tuser <= rau_pkg::ST_ZDEN; st <= S_OUT;
          end else if (s_tuser == 4'(rau_pkg::FN_NORM)) begin
            nmag <= PW'(absw(s_tdata[31:0])); nneg <= s_tdata[W-1];
            dmag <= PW'(absw(s_tdata[63:32])); dneg <= s_tdata[32+W-1];
            m_tuser <= rau_pkg::ST_OK; st <= S_GCD;
          end else st <= S_MUL;
        end
        S_MUL: begin
          prod[mcnt] <= mres;
          mcnt <= mcnt + 1'b1;
          if (mcnt == 2'd3) st <= S_COMB;
        end
        S_COMB: begin
          if (fn >= 4'(rau_pkg::FN_EQ)) begin
            m_tuser <= rau_pkg::ST_OK;
            m_tdata[63] <= cmpr; st <= S_OUT;
          end else begin
            unique case (fn)
              4'(rau_pkg::FN_MUL): begin
                nmag <= prod[3]; nneg <= neg[0] ^ neg[2];
                dmag <= prod[2]; dneg <= neg[1] ^ neg[3];
              end
              4'(rau_pkg::FN_DIV): begin
                nmag <= prod[0]; nneg <= neg[0] ^ neg[3];
                dmag <= prod[1]; dneg <= neg[2] ^ neg[1];
              end
              default: begin
                nmag <= dif_m; nneg <= dif_n;
                dmag <= prod[2]; dneg <= neg[1] ^ neg[3];
              end
            endcase
            if (fn == 4'(rau_pkg::FN_DIV) && prod[1] == '0) begin
              m_tuser <= rau_pkg::ST_ZDEN; st <= S_OUT;
            end else begin
              m_tuser <= rau_pkg::ST_OK; st <= S_GCD;
            end
          end
        end
        S_GCD: if (gdone) st <= S_FIN;
        S_FIN: begin
          if (gd > lim - 1'b1 || (rneg ? gn > lim : gn > lim - 1'b1)) begin
            m_tuser <= rau_pkg::ST_OVF;
          end else begin
            m_tdata[31:0] <= 32'($signed(rneg ? (~gn[W-1:0] + 1'b1) : gn[W-1:0]));
            m_tdata[62:32] <= 31'(gd[W-1:0]);
          end
          st <= S_OUT;
        end
        S_OUT: begin
          m_tvalid <= 1'b1; st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    st != S_IDLE |-> !s_tready) else $error("ready while busy");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != rau_pkg::ST_OK) |-> m_tdata == '0)
    else $error("error result not zero");
  a_den_pos: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == rau_pkg::ST_OK && m_tdata[31:0] != '0) |->
    m_tdata[62:32] != '0) else $error("zero denominator on ok");
`endif
endmodule

// ===== src/rau_gcd.sv =====
// Binary gcd reduction unit: shared subtract/shift datapath, one step a cycle.
// Reduces n/d by their gcd. Depends on nothing.
module rau_gcd #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] n_in,
  input  logic [W-1:0] d_in,
  output logic         done,
  output logic [W-1:0] n_out,
  output logic [W-1:0] d_out
);
  // Phase 1: strip common twos from u,v (counted in k); phase 2: binary gcd;
  // phase 3: divide n,d by g via restoring division, one quotient bit a cycle.
  typedef enum logic [2:0] {S_IDLE, S_TWO, S_GCD, S_DIVN, S_DIVD, S_DONE} st_t;
  localparam int KW = $clog2(W + 1);
  localparam int BW = $clog2(W);
  st_t st;
  logic [W-1:0] u, v, g, n0, d0, rem, quo;
  logic [KW-1:0] k;
  logic [BW-1:0] bitc;

  logic [W:0] trial;
  assign trial = {rem, (st == S_DIVN) ? n0[bitc] : d0[bitc]} - {1'b0, g};

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= (st == S_DONE);
      unique case (st)
        S_IDLE: if (start) begin
          n0 <= n_in; d0 <= d_in; u <= n_in; v <= d_in; k <= '0;
          st <= (n_in == '0) ? S_DIVN : S_TWO;
          if (n_in == '0) begin
            g <= d_in; rem <= '0; quo <= '0; bitc <= BW'(W - 1);
          end
        end
        S_TWO: begin
          if (!u[0] && !v[0]) begin
            u <= u >> 1; v <= v >> 1; k <= k + 1'b1;
          end else st <= S_GCD;
        end
        S_GCD: begin
          if (!u[0]) u <= u >> 1;
          else if (!v[0]) v <= v >> 1;
          else if (u == v) begin
            g <= u << k; rem <= '0; quo <= '0; bitc <= BW'(W - 1);
            st <= S_DIVN;
          end else if (u > v) u <= (u - v) >> 1;
          else v <= (v - u) >> 1;
        end
        S_DIVN, S_DIVD: begin
          if (bitc == '0 && st == S_DIVN) begin
            n_out <= trial[W] ? {quo[W-2:0], 1'b0} : {quo[W-2:0], 1'b1};
            rem <= '0; quo <= '0; bitc <= BW'(W - 1); st <= S_DIVD;
          end else begin
            if (!trial[W]) begin
              rem <= trial[W-1:0]; quo <= {quo[W-2:0], 1'b1};
            end else begin
              rem <= {rem[W-2:0], (st == S_DIVN) ? n0[bitc] : d0[bitc]};
              quo <= {quo[W-2:0], 1'b0};
            end
            if (bitc == '0) begin
              d_out <= trial[W] ? {quo[W-2:0], 1'b0} : {quo[W-2:0], 1'b1};
              st <= S_DONE;
            end else bitc <= bitc - 1'b1;
          end
        end
        S_DONE: begin
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> st == S_IDLE) else $error("gcd start while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done not a pulse");
  a_gcd_odd: assert property (@(posedge clk) disable iff (rst)
    st == S_GCD |-> (u[0] || v[0])) else $error("gcd both even");
`endif
endmodule
